// ----- src/aec_pkg.sv -----
package aec_pkg;

  // number of cells between registers on the collect chain
  localparam int unsigned SEG_LEN = 8;

  typedef enum logic [3:0] {
    V_RECORDED       = 4'd0,
    V_REUSED         = 4'd1,
    V_REPEAT_ALLOC   = 4'd2,
    V_TABLE_FULL     = 4'd3,
    V_RELEASE_OK     = 4'd4,
    V_REPEAT_RELEASE = 4'd5,
    V_KIND_MISMATCH  = 4'd6,
    V_UNKNOWN_ADDR   = 4'd7,
    V_NULL           = 4'd8
  } verdict_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED       = 2'd0,
    ST_RELEASED        = 2'd1,
    ST_REPEAT_RELEASED = 2'd2,
    ST_MISMATCH        = 2'd3
  } status_t;

  // what a cell hands down the collect chain
  typedef struct packed {
    logic        hit;
    logic [31:0] site;
    logic [31:0] size;
    logic        kind;
    logic [1:0]  status;
  } aec_entry_t;

  // write command broadcast to all cells
  typedef struct packed {
    logic        en_full;
    logic        en_status;
    logic [63:0] addr;
    logic [31:0] size;
    logic [31:0] site;
    logic        kind;
    logic [1:0]  status;
  } aec_wr_t;

endpackage

// ----- src/aec_cell.sv -----
module aec_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CNT_W    = 7,
  parameter int unsigned CELL_IDX = 0,
  parameter bit          REG_OUT  = 1'b0
) (
  input  logic                clk,
  input  logic [63:0]         query_addr,
  input  logic [CNT_W-1:0]    used,
  input  aec_pkg::aec_wr_t    wr,
  input  logic [IDX_W-1:0]    wr_idx,
  input  aec_pkg::aec_entry_t chain_in,
  input  logic [IDX_W-1:0]    idx_in,
  output aec_pkg::aec_entry_t chain_out,
  output logic [IDX_W-1:0]    idx_out
);
  import aec_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

  logic [63:0] addr_r;
  logic [31:0] size_r;
  logic [31:0] site_r;
  logic        kind_r;
  logic [1:0]  status_r;
  logic        hit_r;
  logic        live;
  logic        sel;
  aec_entry_t  mine;
  aec_entry_t  merged;
  logic [IDX_W-1:0] idx_merged;

  assign live = (used > MY_CNT);
  assign sel  = (wr_idx == MY_IDX);

  always_ff @(posedge clk) begin
    hit_r <= live && (addr_r == query_addr);
    if (wr.en_full && sel) begin
      addr_r   <= wr.addr;
      size_r   <= wr.size;
      site_r   <= wr.site;
      kind_r   <= wr.kind;
      status_r <= wr.status;
    end else if (wr.en_status && sel) begin
      status_r <= wr.status;
    end
  end

  always_comb begin
    mine.hit    = 1'b1;
    mine.site   = site_r;
    mine.size   = size_r;
    mine.kind   = kind_r;
    mine.status = status_r;
  end

  // at most one cell holds a given address, so an OR merges the chain
  assign merged     = chain_in | (hit_r ? mine : '0);
  assign idx_merged = idx_in | (hit_r ? MY_IDX : '0);

  if (REG_OUT) begin : g_reg
    aec_entry_t       chain_r;
    logic [IDX_W-1:0] idx_r;
    always_ff @(posedge clk) begin
      chain_r <= merged;
      idx_r   <= idx_merged;
    end
    assign chain_out = chain_r;
    assign idx_out   = idx_r;
  end else begin : g_comb
    assign chain_out = merged;
    assign idx_out   = idx_merged;
  end

endmodule

// ----- src/allocation_event_checker_core.sv -----
// Allocation event checker: one event in, one verdict out.
// Steps from input transfer to result: the per-cell address compare, one register per 8-cell
//   segment of the collect chain, then the decision, which loads the output register once
//   that register is free. One event is in work at a time.
// A new event is accepted only after the previous result is loaded into the output register.
// Reset (rst_n low, synchronous): fill count and handshake state clear; table contents are not.
module allocation_event_checker_core #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] address, [95:64] block_size, [127:96] site_tag
  input  logic [1:0]   in_tuser,   // [1:0] mode
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // [5:0] slot, [37:6] prior_site, [69:38] prior_size,
                                   // [70] prior_kind, [71] zero fill
  output logic [3:0]   out_tuser   // [3:0] verdict
);
  import aec_pkg::*;

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SLOT_W = (IDX_W > 6) ? IDX_W : 6;
  // number of collect-chain segments, counted down while the chain settles after the compare
  localparam int unsigned NWAIT  = (TABLE_ENTRIES + SEG_LEN - 1) / SEG_LEN;
  localparam int unsigned WAIT_W = (NWAIT > 1) ? $clog2(NWAIT) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_MATCH   = 4'b0010,
    S_COLLECT = 4'b0100,
    S_DECIDE  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;

  // held event
  logic [1:0]  mode_r;
  logic [63:0] addr_r;
  logic [31:0] size_r;
  logic [31:0] site_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  verdict_r;
  logic [5:0]  slot_r;
  logic [31:0] psite_r;
  logic [31:0] psize_r;
  logic        pkind_r;

  logic        in_xfer;
  logic        out_free;
  logic        decide_go;

  // collect chain
  aec_entry_t       link   [0:TABLE_ENTRIES];
  logic [IDX_W-1:0] link_i [0:TABLE_ENTRIES];
  aec_entry_t       found;
  logic [IDX_W-1:0] found_idx;

  // decision
  aec_wr_t          wr;
  logic [IDX_W-1:0] wr_idx;
  verdict_t         verdict;
  logic [SLOT_W-1:0] slot_ext;
  logic             report_prior;
  logic             rec_new;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign decide_go = (state_r == S_DECIDE) && out_free;

  assign link[0]   = '0;
  assign link_i[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    aec_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (i),
      .REG_OUT  ((i % SEG_LEN) == (SEG_LEN - 1))
    ) u_cell (
      .clk        (clk),
      .query_addr (addr_r),
      .used       (used_r),
      .wr         (wr),
      .wr_idx     (wr_idx),
      .chain_in   (link[i]),
      .idx_in     (link_i[i]),
      .chain_out  (link[i+1]),
      .idx_out    (link_i[i+1])
    );
  end

  assign found     = link[TABLE_ENTRIES];
  assign found_idx = link_i[TABLE_ENTRIES];

  // classify the event and build the table write
  always_comb begin
    verdict      = V_NULL;
    report_prior = 1'b0;
    rec_new      = 1'b0;
    wr_idx       = found_idx;
    wr.en_full   = 1'b0;
    wr.en_status = 1'b0;
    wr.addr      = addr_r;
    wr.size      = size_r;
    wr.site      = site_r;
    wr.kind      = mode_r[0];
    wr.status    = ST_ALLOCATED;
    slot_ext     = '0;
    if (addr_r != 64'd0) begin
      if (!mode_r[1]) begin
        // allocate
        if (found.hit) begin
          report_prior = 1'b1;
          slot_ext     = SLOT_W'(found_idx);
          if (found.status == ST_ALLOCATED) begin
            verdict = V_REPEAT_ALLOC;
          end else begin
            verdict    = V_REUSED;
            wr.en_full = 1'b1;
          end
        end else if (used_r != FULL_CNT) begin
          verdict    = V_RECORDED;
          rec_new    = 1'b1;
          wr.en_full = 1'b1;
          wr_idx     = IDX_W'(used_r);
          slot_ext   = SLOT_W'(used_r);
        end else begin
          verdict = V_TABLE_FULL;
        end
      end else begin
        // release
        if (!found.hit) begin
          verdict = V_UNKNOWN_ADDR;
        end else begin
          report_prior = 1'b1;
          slot_ext     = SLOT_W'(found_idx);
          wr.en_status = 1'b1;
          if (found.status != ST_ALLOCATED) begin
            verdict   = V_REPEAT_RELEASE;
            wr.status = ST_REPEAT_RELEASED;
          end else if (found.kind != mode_r[0]) begin
            verdict   = V_KIND_MISMATCH;
            wr.status = ST_MISMATCH;
          end else begin
            verdict   = V_RELEASE_OK;
            wr.status = ST_RELEASED;
          end
        end
      end
    end
    // table changes only on the cycle the result is loaded
    if (!decide_go) begin
      wr.en_full   = 1'b0;
      wr.en_status = 1'b0;
      rec_new      = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    wait_nxt      = wait_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_COLLECT;
        wait_nxt  = WAIT_W'(NWAIT - 1);
      end
      S_COLLECT: begin
        if (wait_r == '0) begin
          state_nxt = S_DECIDE;
        end else begin
          wait_nxt = wait_r - 1'b1;
        end
      end
      S_DECIDE: begin
        if (decide_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (rec_new) begin
            used_nxt = used_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // event capture and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= in_tuser;
      addr_r <= in_tdata[63:0];
      size_r <= in_tdata[95:64];
      site_r <= in_tdata[127:96];
    end
    if (decide_go) begin
      verdict_r <= verdict;
      slot_r    <= slot_ext[5:0];
      psite_r   <= report_prior ? found.site : 32'd0;
      psize_r   <= report_prior ? found.size : 32'd0;
      pkind_r   <= report_prior ? found.kind : 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = verdict_r;
  assign out_tdata  = {1'b0, pkind_r, psize_r, psite_r, slot_r};

endmodule

// ----- test/allocation_event_checker_core_test.sv -----
`timescale 1ns / 1ps

module allocation_event_checker_core_test;
  import aec_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned POOL_SIZE     = 72;   // a few more than the table holds
  localparam int unsigned RANDOM_EVENTS = 1700;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned HOLD_AFTER    = 500;  // input transfers before the long hold

  // event kinds as they travel on in_tuser
  typedef enum logic [1:0] {
    EV_ALLOC_SCALAR = 2'd0,
    EV_ALLOC_ARRAY  = 2'd1,
    EV_FREE_SCALAR  = 2'd2,
    EV_FREE_ARRAY   = 2'd3
  } event_mode_t;

  // one predicted result transfer
  typedef struct {
    verdict_t    verdict;
    logic [5:0]  slot;
    logic [31:0] site;
    logic [31:0] size;
    logic        kind;
  } alloc_verdict_t;

  // Shadow allocation table plus the FIFO of verdicts still owed by the block.
  class alloc_table_scoreboard;
    logic [63:0] tbl_addr   [TABLE_ENTRIES];
    logic [31:0] tbl_size   [TABLE_ENTRIES];
    logic [31:0] tbl_site   [TABLE_ENTRIES];
    logic        tbl_kind   [TABLE_ENTRIES];
    status_t     tbl_status [TABLE_ENTRIES];
    int unsigned    used;
    alloc_verdict_t verdicts_due[$];
    int unsigned    errors;
    int unsigned    results_seen;

    function int lookup(logic [63:0] addr);
      for (int i = 0; i < used; i++)
        if (tbl_addr[i] == addr) return i;
      return -1;
    endfunction

    // kind of a live block at addr, or -1 when untracked or already released
    function int live_kind(logic [63:0] addr);
      int idx;
      idx = lookup(addr);
      if (idx < 0 || tbl_status[idx] != ST_ALLOCATED) return -1;
      return int'(tbl_kind[idx]);
    endfunction

    function void store(int idx, logic [63:0] addr, logic [31:0] size, logic [31:0] site,
                        logic kind);
      tbl_addr[idx]   = addr;
      tbl_size[idx]   = size;
      tbl_site[idx]   = site;
      tbl_kind[idx]   = kind;
      tbl_status[idx] = ST_ALLOCATED;
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction

    // classify one accepted event and advance the shadow table
    function void note_event(logic [1:0] mode, logic [127:0] data);
      alloc_verdict_t r;
      logic [63:0] addr;
      logic [31:0] size;
      logic [31:0] site;
      logic        kind;
      logic        is_alloc;
      int          idx;
      addr     = data[63:0];
      size     = data[95:64];
      site     = data[127:96];
      kind     = (mode == EV_ALLOC_ARRAY || mode == EV_FREE_ARRAY);
      is_alloc = (mode == EV_ALLOC_SCALAR || mode == EV_ALLOC_ARRAY);
      r.verdict = V_NULL;
      r.slot    = '0;
      r.site    = '0;
      r.size    = '0;
      r.kind    = 1'b0;
      if (addr != '0) begin
        idx = lookup(addr);
        if (idx >= 0) begin
          r.slot = idx[5:0];
          r.site = tbl_site[idx];
          r.size = tbl_size[idx];
          r.kind = tbl_kind[idx];
        end
        if (is_alloc) begin
          if (idx >= 0) begin
            if (tbl_status[idx] == ST_ALLOCATED) begin
              r.verdict = V_REPEAT_ALLOC;
            end else begin
              store(idx, addr, size, site, kind);
              r.verdict = V_REUSED;
            end
          end else if (used < TABLE_ENTRIES) begin
            r.slot = used[5:0];
            store(used, addr, size, site, kind);
            used++;
            r.verdict = V_RECORDED;
          end else begin
            r.verdict = V_TABLE_FULL;
          end
        end else if (idx < 0) begin
          r.verdict = V_UNKNOWN_ADDR;
        end else if (tbl_status[idx] != ST_ALLOCATED) begin
          // any flavor of released entry collapses to repeat released
          tbl_status[idx] = ST_REPEAT_RELEASED;
          r.verdict = V_REPEAT_RELEASE;
        end else if (tbl_kind[idx] != kind) begin
          tbl_status[idx] = ST_MISMATCH;
          r.verdict = V_KIND_MISMATCH;
        end else begin
          tbl_status[idx] = ST_RELEASED;
          r.verdict = V_RELEASE_OK;
        end
      end
      verdicts_due.push_back(r);
    endfunction

    task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 40)
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 results_seen, field, got, want);
    endtask

    task check_result(logic [3:0] verdict, logic [71:0] data);
      alloc_verdict_t r;
      if (verdicts_due.size() == 0) begin
        report_mismatch("unexpected transfer, verdict", verdict, '0);
      end else begin
        r = verdicts_due.pop_front();
        if (verdict    !== r.verdict) report_mismatch("verdict",    verdict,       r.verdict);
        if (data[5:0]  !== r.slot)    report_mismatch("slot",       data[5:0],     r.slot);
        if (data[37:6] !== r.site)    report_mismatch("prior_site", data[37:6],    r.site);
        if (data[69:38] !== r.size)   report_mismatch("prior_size", data[69:38],   r.size);
        if (data[70]   !== r.kind)    report_mismatch("prior_kind", data[70],      r.kind);
        if (data[71]   !== 1'b0)      report_mismatch("fill bit",   data[71],      1'b0);
      end
      results_seen++;
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;    // [63:0] address, [95:64] block_size, [127:96] site_tag
  logic [1:0]   in_tuser = '0;    // [1:0] mode
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;        // [5:0] slot, [37:6] prior_site, [69:38] prior_size,
                                  // [70] prior_kind, [71] zero fill
  logic [3:0]   out_tuser;        // [3:0] verdict

  alloc_table_scoreboard sb = new();

  logic [63:0] addr_pool [POOL_SIZE];
  bit          calm = 1'b0;       // set for a stretch with no idling on either side
  int unsigned events_in = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  allocation_event_checker_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // both transfers sampled on the edge, before any driver update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_event(in_tuser, in_tdata);
        events_in++;
      end
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata);
    end
  end

  // Result side: random stalls, plus one long hold-off while the sender keeps
  // offering events so the block backs up and drops in_tready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && events_in >= HOLD_AFTER) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  // Offer one event and hold it until it transfers. Valid stays high on return
  // so back-to-back events need no extra edge.
  task send_event(event_mode_t mode, logic [63:0] addr, logic [31:0] size, logic [31:0] site);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {site, size, addr};
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // sender goes quiet until every owed verdict is back
  task wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  initial begin
    logic [63:0] addr;
    int          pick;
    int          k;
    bit          dup;
    event_mode_t mode;

    // random pool of distinct nonzero addresses, clear of the directed ones
    for (int i = 0; i < POOL_SIZE; i++) begin
      do begin
        addr = {$urandom, $urandom};
        dup  = (addr == '0) || (addr == '1) || (addr == 64'd1) || (addr[63] && addr[62:0] == '0);
        for (int j = 0; j < i; j++)
          if (addr_pool[j] == addr) dup = 1'b1;
      end while (dup);
      addr_pool[i] = addr;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: null events, field extremes, every release outcome, reuse
    send_event(EV_ALLOC_SCALAR, '0, '1, '1);                 // null ignored
    send_event(EV_FREE_ARRAY,   '0, '0, '0);                 // null ignored
    send_event(EV_ALLOC_SCALAR, '1, '1, '1);                 // recorded, slot 0
    send_event(EV_ALLOC_ARRAY,  64'd1, '0, '0);              // recorded, slot 1
    send_event(EV_ALLOC_ARRAY,  '1, 32'd5, 32'd7);           // repeat alloc of live block
    send_event(EV_FREE_ARRAY,   '1, '0, 32'd3);              // kind mismatch
    send_event(EV_FREE_SCALAR,  '1, '1, 32'd4);              // repeat release of mismatched entry
    send_event(EV_FREE_ARRAY,   64'd1, '0, '1);              // release ok
    send_event(EV_FREE_ARRAY,   64'd1, '0, '0);              // repeat release
    send_event(EV_FREE_SCALAR,  64'd1, '0, '0);              // repeat release, other kind
    send_event(EV_FREE_SCALAR,  {1'b1, 63'd0}, '0, '0);      // unknown address
    send_event(EV_ALLOC_SCALAR, 64'd1, 32'h5555_5555, 32'hAAAA_AAAA);  // reuse
    send_event(EV_ALLOC_ARRAY,  '1, '0, '0);                 // reuse after repeat release
    send_event(EV_FREE_SCALAR,  '1, '0, '0);                 // kind mismatch
    send_event(EV_ALLOC_ARRAY,  '1, 32'd1, 32'd1);           // reuse after mismatch
    send_event(EV_FREE_ARRAY,   '1, '0, '0);                 // release ok
    send_event(EV_FREE_SCALAR,  64'd1, '0, '0);              // release ok
    send_event(EV_FREE_ARRAY,   {1'b1, 63'd0}, '0, '0);      // unknown address

    // fill the table from the pool, last few land on a full table
    for (int i = 0; i < POOL_SIZE - 2; i++)
      send_event(i[0] ? EV_ALLOC_ARRAY : EV_ALLOC_SCALAR, addr_pool[i], pick_word(), pick_word());

    // random traffic, mostly alloc/release pairs on pool addresses
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      calm = (n >= 700 && n < 1000);
      if (n == 1300) wait_for_drain();
      pick = $urandom_range(0, 99);
      if (pick < 4)       addr = '0;
      else if (pick < 10) addr = {$urandom, $urandom};
      else                addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      mode = event_mode_t'($urandom_range(0, 3));
      if (pick >= 10 && $urandom_range(0, 99) < 70) begin
        k = sb.live_kind(addr);
        if (k < 0)       mode = $urandom_range(0, 1) ? EV_ALLOC_ARRAY : EV_ALLOC_SCALAR;
        else if (k == 1) mode = EV_FREE_ARRAY;
        else             mode = EV_FREE_SCALAR;
      end
      send_event(mode, addr, pick_word(), pick_word());
    end
    calm = 1'b0;

    wait_for_drain();
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
